FILE: rtl/btpc_pkg.sv
`timescale 1ns / 1ps
package btpc_pkg;

  localparam int unsigned DivBits     = 32;
  localparam int unsigned FrontStages = 12;

  localparam logic [31:0] FineOffset  = 32'd64000;
  localparam logic [31:0] RawPressTop = 32'h0010_0000;
  localparam logic [31:0] PressScale  = 32'd3125;
  localparam logic [31:0] SignBit     = 32'h8000_0000;
  localparam logic [31:0] OneHalfP1   = 32'd32768;
  localparam logic [31:0] TempRound   = 32'd128;

  localparam logic [1:0] RegTempCoeffs = 2'd0;
  localparam logic [1:0] RegPressA     = 2'd1;
  localparam logic [1:0] RegPressB     = 2'd2;
  localparam logic [1:0] RegPressLast  = 2'd3;

  // Values that ride alongside the divider.
  typedef struct packed {
    logic [31:0] fine;
    logic [23:0] tc;
    logic [31:0] divisor;
    logic        dbl;
    logic        zero;
  } side_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

FILE: rtl/baro_temp_press_compensation.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake                     | Payload
// command   | in        | start_i, busy_o               | raw_temperature_i, raw_pressure_i
// result    | out       | result_valid_o (one cycle)    | temperature_centi_o, pressure_pa_o,
//           |           |                               | fine_temperature_o, divisor_zero_o
// config    | in        | cfg_valid_i, cfg_ready_o      | cfg_index_i, cfg_data_i
//
// One beat is accepted in every cycle; busy_o stays low. The beat passes 47 register
// stages: 12 arithmetic stages, a 32-stage restoring divider that resolves one quotient
// bit per stage, and 3 correction stages, before its result reaches the ports.
// Reset is asynchronous and active low; it clears the valid bits and the calibration.
// The receiver cannot stall, so the pipeline always advances and never drops a beat.
module baro_temp_press_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [19:0] raw_temperature_i,
  input  logic [19:0] raw_pressure_i,
  output logic        result_valid_o,
  output logic [23:0] temperature_centi_o,
  output logic [31:0] pressure_pa_o,
  output logic [31:0] fine_temperature_o,
  output logic        divisor_zero_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import btpc_pkg::*;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Calibration registers.
  logic [47:0] temp_coeffs_q;
  logic [63:0] press_a_q, press_b_q;
  logic [15:0] press_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      press_a_q     <= '0;
      press_b_q     <= '0;
      press_last_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegTempCoeffs: temp_coeffs_q <= cfg_data_i[47:0];
        RegPressA:     press_a_q     <= cfg_data_i;
        RegPressB:     press_b_q     <= cfg_data_i;
        RegPressLast:  press_last_q  <= cfg_data_i[15:0];
        default:       temp_coeffs_q <= temp_coeffs_q;
      endcase
    end
  end

  // Calibration must be written only while idle (the block does not enforce this), so every stage may read it directly.
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, temp_coeffs_q[15:0]};
  assign t2 = sx16(temp_coeffs_q[31:16]);
  assign t3 = sx16(temp_coeffs_q[47:32]);
  assign p1 = {16'd0, press_a_q[15:0]};
  assign p2 = sx16(press_a_q[31:16]);
  assign p3 = sx16(press_a_q[47:32]);
  assign p4 = sx16(press_a_q[63:48]);
  assign p5 = sx16(press_b_q[15:0]);
  assign p6 = sx16(press_b_q[31:16]);
  assign p7 = sx16(press_b_q[47:32]);
  assign p8 = sx16(press_b_q[63:48]);
  assign p9 = sx16(press_last_q);

  // Valid bits of the front stages, the divider and the tail.
  logic [FrontStages-1:0] fv_q;
  logic [DivBits-1:0]     dv_q;
  logic [2:0]             tv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
      dv_q <= '0;
      tv_q <= '0;
    end else begin
      fv_q <= {fv_q[FrontStages-2:0], start_i};
      dv_q <= {dv_q[DivBits-2:0], fv_q[FrontStages-1]};
      tv_q <= {tv_q[1:0], dv_q[DivBits-1]};
    end
  end

  // Front stages. The raw pressure travels alongside until it is used in stage ten.
  logic [19:0] rp_q [1:9];
  logic [31:0] s1_x_q, s1_d_q;
  logic [31:0] s2_m_q, s2_dd_q;
  logic [31:0] s3_a_q, s3_e_q;
  logic [31:0] s4_fine_q;
  logic [31:0] s5_fine_q, s5_pa_q, s5_q_q;
  logic [23:0] s5_tc_q;
  logic [31:0] s6_fine_q, s6_sq_q, s6_m5_q, s6_m2_q;
  logic [23:0] s6_tc_q;
  logic [31:0] s7_fine_q, s7_b6_q, s7_m3_q, s7_m5_q, s7_m2_q;
  logic [23:0] s7_tc_q;
  logic [31:0] s8_fine_q, s8_b_q, s8_a_q;
  logic [23:0] s8_tc_q;
  logic [31:0] s9_fine_q, s9_b_q, s9_am_q;
  logic [23:0] s9_tc_q;
  logic [31:0] s10_fine_q, s10_x_q, s10_div_q;
  logic [23:0] s10_tc_q;
  logic [31:0] s11_fine_q, s11_pn_q, s11_div_q;
  logic [23:0] s11_tc_q;

  logic [31:0] fine5, tc_full, b_sum;
  assign fine5   = {s4_fine_q[29:0], 2'b00} + s4_fine_q;
  assign tc_full = asr(fine5 + TempRound, 5'd8);
  assign b_sum   = s7_b6_q + {s7_m5_q[30:0], 1'b0};

  always_ff @(posedge clk_i) begin
    rp_q[1] <= raw_pressure_i;
    for (int i = 2; i <= 9; i++) begin
      rp_q[i] <= rp_q[i-1];
    end
    s1_x_q     <= {15'd0, raw_temperature_i[19:3]} - {t1[30:0], 1'b0};
    s1_d_q     <= {16'd0, raw_temperature_i[19:4]} - t1;
    s2_m_q     <= s1_x_q * t2;
    s2_dd_q    <= s1_d_q * s1_d_q;
    s3_a_q     <= asr(s2_m_q, 5'd11);
    s3_e_q     <= asr(s2_dd_q, 5'd12) * t3;
    s4_fine_q  <= s3_a_q + asr(s3_e_q, 5'd14);
    // The rounded temperature always fits 24 bits, so its low 24 bits lose nothing and the testbench clamp never bites.
    s5_fine_q  <= s4_fine_q;
    s5_tc_q    <= tc_full[23:0];
    s5_pa_q    <= asr(s4_fine_q, 5'd1) - FineOffset;
    s5_q_q     <= asr(asr(s4_fine_q, 5'd1) - FineOffset, 5'd2);
    s6_fine_q  <= s5_fine_q;
    s6_tc_q    <= s5_tc_q;
    s6_sq_q    <= s5_q_q * s5_q_q;
    s6_m5_q    <= s5_pa_q * p5;
    s6_m2_q    <= p2 * s5_pa_q;
    s7_fine_q  <= s6_fine_q;
    s7_tc_q    <= s6_tc_q;
    s7_b6_q    <= asr(s6_sq_q, 5'd11) * p6;
    s7_m3_q    <= p3 * asr(s6_sq_q, 5'd13);
    s7_m5_q    <= s6_m5_q;
    s7_m2_q    <= s6_m2_q;
    s8_fine_q  <= s7_fine_q;
    s8_tc_q    <= s7_tc_q;
    s8_b_q     <= asr(b_sum, 5'd2) + {p4[15:0], 16'd0};
    s8_a_q     <= asr(asr(s7_m3_q, 5'd3) + asr(s7_m2_q, 5'd1), 5'd18);
    s9_fine_q  <= s8_fine_q;
    s9_tc_q    <= s8_tc_q;
    s9_b_q     <= s8_b_q;
    s9_am_q    <= (OneHalfP1 + s8_a_q) * p1;
    s10_fine_q <= s9_fine_q;
    s10_tc_q   <= s9_tc_q;
    s10_div_q  <= asr(s9_am_q, 5'd15);
    s10_x_q    <= (RawPressTop - {12'd0, rp_q[9]}) - asr(s9_b_q, 5'd12);
    s11_fine_q <= s10_fine_q;
    s11_tc_q   <= s10_tc_q;
    s11_div_q  <= s10_div_q;
    s11_pn_q   <= s10_x_q * PressScale;
  end

  // Stage twelve picks the dividend: doubled before dividing when that cannot overflow,
  // otherwise the quotient is doubled afterwards.
  side_t       s12_side_q;
  logic [31:0] s12_num_q;

  always_ff @(posedge clk_i) begin
    s12_side_q.fine    <= s11_fine_q;
    s12_side_q.tc      <= s11_tc_q;
    s12_side_q.divisor <= s11_div_q;
    s12_side_q.zero    <= (s11_div_q == '0);
    s12_side_q.dbl     <= (s11_pn_q >= SignBit);
    s12_num_q          <= (s11_pn_q >= SignBit) ? s11_pn_q : {s11_pn_q[30:0], 1'b0};
  end

  // Restoring divider, one quotient bit per stage.
  side_t       dsd_q  [DivBits];
  logic [31:0] drem_q [DivBits];
  logic [31:0] dnum_q [DivBits];
  logic [31:0] dquo_q [DivBits];

  for (genvar k = 0; k < DivBits; k++) begin : g_div
    side_t       side_in;
    logic [31:0] rem_in, num_in, quo_in;
    logic [32:0] trial, diff;

    if (k == 0) begin : g_first
      assign side_in = s12_side_q;
      assign rem_in  = '0;
      assign num_in  = s12_num_q;
      assign quo_in  = '0;
    end else begin : g_next
      assign side_in = dsd_q[k-1];
      assign rem_in  = drem_q[k-1];
      assign num_in  = dnum_q[k-1];
      assign quo_in  = dquo_q[k-1];
    end

    assign trial = {rem_in, num_in[31]};
    assign diff  = trial - {1'b0, side_in.divisor};

    always_ff @(posedge clk_i) begin
      dsd_q[k]  <= side_in;
      dnum_q[k] <= {num_in[30:0], 1'b0};
      if (!diff[32]) begin
        drem_q[k] <= diff[31:0];
        dquo_q[k] <= {quo_in[30:0], 1'b1};
      end else begin
        drem_q[k] <= trial[31:0];
        dquo_q[k] <= {quo_in[30:0], 1'b0};
      end
    end
  end

  // Tail: second-order pressure correction.
  side_t       last_side;
  logic [31:0] quo_last, p_base;
  assign last_side = dsd_q[DivBits-1];
  assign quo_last  = dquo_q[DivBits-1];
  assign p_base    = last_side.zero ? '0 :
                     (last_side.dbl ? {quo_last[30:0], 1'b0} : quo_last);

  side_t       t1_side_q, t2_side_q;
  logic [31:0] t1_p_q, t1_sq_q, t1_mb_q;
  logic [31:0] t2_p_q, t2_ma_q, t2_mb_q;
  logic [31:0] corr;

  assign corr = asr(asr(t2_ma_q, 5'd12) + asr(t2_mb_q, 5'd13) + p7, 5'd4);

  always_ff @(posedge clk_i) begin
    t1_side_q <= last_side;
    t1_p_q    <= p_base;
    t1_sq_q   <= {3'd0, p_base[31:3]} * {3'd0, p_base[31:3]};
    t1_mb_q   <= {2'd0, p_base[31:2]} * p8;
    t2_side_q <= t1_side_q;
    t2_p_q    <= t1_p_q;
    t2_ma_q   <= p9 * {13'd0, t1_sq_q[31:13]};
    t2_mb_q   <= t1_mb_q;
    temperature_centi_o <= t2_side_q.tc;
    fine_temperature_o  <= t2_side_q.fine;
    divisor_zero_o      <= t2_side_q.zero;
    pressure_pa_o       <= t2_side_q.zero ? '0 : t2_p_q + corr;
  end

  assign result_valid_o = tv_q[2];

endmodule

FILE: tb/baro_temp_press_compensation_tb.sv
`timescale 1ns / 1ps
module baro_temp_press_compensation_tb;
  import btpc_pkg::*;

  // Readings and their expected compensated values.
  typedef struct packed {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
  } reading_t;

  typedef struct packed {
    logic [23:0] temp_centi;
    logic [31:0] press_pa;
    logic [31:0] fine;
    logic        div_zero;
  } comp_t;

  // The drain and the watchdog allow plenty beyond the depth of the pipeline.
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned StallLimit  = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [19:0] raw_temperature_i = '0;
  logic [19:0] raw_pressure_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = RegTempCoeffs;
  logic [63:0] cfg_data_i = '0;
  logic        busy_o, result_valid_o, divisor_zero_o, cfg_ready_o;
  logic [23:0] temperature_centi_o;
  logic [31:0] pressure_pa_o, fine_temperature_o;

  baro_temp_press_compensation u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .raw_temperature_i, .raw_pressure_i,
    .result_valid_o, .temperature_centi_o, .pressure_pa_o, .fine_temperature_o,
    .divisor_zero_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // The testbench's own copy of the calibration.
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a, cal_press_b;
  logic [15:0] cal_p9;

  reading_t    readings_pending[$];
  comp_t       comp_expected[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit          no_gaps;
  bit          timed_out;

  function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Works out the compensated temperature and pressure of one reading.
  function automatic comp_t compensate(input reading_t r);
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] rt, rp, a, b, d, fine, tc, p, q, sq;
    comp_t res;
    t1 = {16'd0, cal_temp[15:0]};
    t2 = ext16(cal_temp[31:16]);
    t3 = ext16(cal_temp[47:32]);
    p1 = {16'd0, cal_press_a[15:0]};
    p2 = ext16(cal_press_a[31:16]);
    p3 = ext16(cal_press_a[47:32]);
    p4 = ext16(cal_press_a[63:48]);
    p5 = ext16(cal_press_b[15:0]);
    p6 = ext16(cal_press_b[31:16]);
    p7 = ext16(cal_press_b[47:32]);
    p8 = ext16(cal_press_b[63:48]);
    p9 = ext16(cal_p9);
    rt = {12'd0, r.raw_t};
    rp = {12'd0, r.raw_p};

    a = sra32(((rt >> 3) - (t1 << 1)) * t2, 11);
    d = (rt >> 4) - t1;
    b = sra32(sra32(d * d, 12) * t3, 14);
    fine = a + b;
    tc = sra32(fine * 32'd5 + 32'd128, 8);
    // Saturate to the 24-bit signed field.
    if ($signed(tc) > 32'sd8388607) tc = 32'd8388607;
    else if ($signed(tc) < -32'sd8388608) tc = 32'hFF80_0000;

    a = sra32(fine, 1) - 32'd64000;
    q = sra32(a, 2);
    sq = q * q;
    b = sra32(sq, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra32(b, 2) + (p4 << 16);
    a = sra32(sra32(p3 * sra32(sq, 13), 3) + sra32(p2 * a, 1), 18);
    a = sra32((32'd32768 + a) * p1, 15);

    res.div_zero = (a == 32'd0);
    if (res.div_zero) begin
      p = 32'd0;
    end else begin
      p = ((32'h0010_0000 - rp) - sra32(b, 12)) * 32'd3125;
      // The divisor is treated as unsigned.
      if (p < 32'h8000_0000) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      a = sra32(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      b = sra32((p >> 2) * p8, 13);
      p = p + sra32(a + b + p7, 4);
    end
    res.temp_centi = tc[23:0];
    res.press_pa = p;
    res.fine = fine;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Driver: presents queued readings, with random gaps except while no_gaps is set.
  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      comp_expected.push_back(compensate({raw_temperature_i, raw_pressure_i}));
    end
    if (!(start_i && busy_o)) begin
      if (readings_pending.size() > 0 && (no_gaps || $urandom_range(99) >= 27)) begin
        reading_t r;
        r = readings_pending.pop_front();
        start_i <= 1'b1;
        raw_temperature_i <= r.raw_t;
        raw_pressure_i <= r.raw_p;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: every strobed beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (comp_expected.size() == 0) begin
        report_mismatch("unexpected result beat, pressure_pa", pressure_pa_o, 32'd0);
      end else begin
        comp_t want;
        want = comp_expected.pop_front();
        if (temperature_centi_o !== want.temp_centi)
          report_mismatch("temperature_centi", {8'd0, temperature_centi_o},
                          {8'd0, want.temp_centi});
        if (pressure_pa_o !== want.press_pa)
          report_mismatch("pressure_pa", pressure_pa_o, want.press_pa);
        if (fine_temperature_o !== want.fine)
          report_mismatch("fine_temperature", fine_temperature_o, want.fine);
        if (divisor_zero_o !== want.div_zero)
          report_mismatch("divisor_zero", {31'd0, divisor_zero_o}, {31'd0, want.div_zero});
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegTempCoeffs: cal_temp = val[47:0];
      RegPressA:     cal_press_a = val;
      RegPressB:     cal_press_b = val;
      default:       cal_p9 = val[15:0];
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_calibration(input logic [47:0] tc, input logic [63:0] pa,
                                  input logic [63:0] pb, input logic [15:0] p9);
    write_reg(RegTempCoeffs, {16'd0, tc});
    write_reg(RegPressA, pa);
    write_reg(RegPressB, pb);
    write_reg(RegPressLast, {48'd0, p9});
  endtask

  // Waits until the pipeline has drained, then for a further margin set by DrainCycles.
  task automatic drain;
    while (readings_pending.size() > 0 || start_i || comp_expected.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // A typical datasheet-like calibration, which keeps the divisor non-zero.
  function automatic logic [63:0] typical_a();
    return {16'($urandom_range(2000, 9000)), 16'(-$urandom_range(3000, 100)),
            16'(-$urandom_range(10700, 10000)), 16'($urandom_range(40000, 32768))};
  endfunction

  function automatic logic [63:0] typical_b();
    return {16'($urandom_range(4000, 0) - 2000), 16'($urandom_range(20000, 0)),
            16'(-$urandom_range(20, 0)), 16'($urandom_range(300, 0))};
  endfunction

  function automatic logic [47:0] typical_t();
    return {16'($urandom_range(60000, 0) - 30000), 16'($urandom_range(30000, 20000)),
            16'($urandom_range(30000, 25000))};
  endfunction

  function automatic logic [19:0] near_raw();
    return 20'($urandom_range(600000, 400000));
  endfunction

  function automatic reading_t any_reading();
    return {20'($urandom()), 20'($urandom())};
  endfunction

  initial begin
    cal_temp = '0;
    cal_press_a = '0;
    cal_press_b = '0;
    cal_p9 = '0;
    mismatch_count = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    timed_out = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With the reset calibration every divisor is zero.
    readings_pending.push_back({20'd0, 20'd0});
    readings_pending.push_back({20'hFFFFF, 20'hFFFFF});
    drain();

    // Directed readings on a typical calibration: field extremes and the usual range.
    load_calibration(48'h_CC88_6A4F_6C70, 64'h_1E8F_D70C_D5C9_9270, 64'h_FFF9_8C35_FFF9_008A,
                     16'd6000);
    readings_pending.push_back({20'd0, 20'd0});
    readings_pending.push_back({20'hFFFFF, 20'd0});
    readings_pending.push_back({20'd0, 20'hFFFFF});
    readings_pending.push_back({20'hFFFFF, 20'hFFFFF});
    readings_pending.push_back({20'h80000, 20'h80000});
    readings_pending.push_back({20'h7FFFF, 20'h55555});
    readings_pending.push_back({20'h555AA, 20'hAAAAA});
    for (int i = 0; i < 8; i++) readings_pending.push_back({near_raw(), near_raw()});
    drain();

    // Extreme calibration words: all ones and the most negative signed values.
    load_calibration({48{1'b1}}, {64{1'b1}}, {64{1'b1}}, 16'hFFFF);
    readings_pending.push_back({20'd0, 20'hFFFFF});
    readings_pending.push_back({20'hFFFFF, 20'd0});
    drain();
    load_calibration(48'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000,
                     16'h8000);
    readings_pending.push_back({20'd0, 20'd0});
    readings_pending.push_back({20'hFFFFF, 20'hFFFFF});
    drain();

    // Random phases: mostly typical calibrations with realistic readings, some noise.
    for (int phase = 0; phase < 10; phase++) begin
      if (phase % 3 == 2)
        load_calibration(48'(rand64()), rand64(), rand64(), 16'($urandom()));
      else
        load_calibration(typical_t(), typical_a(), typical_b(), 16'($urandom_range(20000, 0)));
      no_gaps = (phase == 4);
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(3) == 0) readings_pending.push_back(any_reading());
        else readings_pending.push_back({near_raw(), near_raw()});
      end
      drain();
    end
  end

  // Ends the run once everything has drained, or when the watchdog trips.
  initial begin
    wait (rst_ni);
    fork
      begin
        wait (idle_cycles >= StallLimit);
        timed_out = 1'b1;
      end
      begin
        // The stimulus process leaves the queue empty once its last phase has drained.
        repeat (200) @(posedge clk_i);
        forever begin
          @(posedge clk_i);
          if (readings_pending.size() == 0 && !start_i && comp_expected.size() == 0
              && idle_cycles > DrainCycles + 40) break;
        end
      end
    join_any
    if (timed_out || mismatch_count != 0 || comp_expected.size() != 0) begin
      $display("** baro_temp_press_compensation: FAILED **");
    end else begin
      $display("** baro_temp_press_compensation: PASSED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/btpc_pkg.sv
rtl/baro_temp_press_compensation.sv
tb/baro_temp_press_compensation_tb.sv
